FILE: src/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg: shared types and constants of the charge port monitor
// Event codes, decoded event format, register layout and arithmetic constants.
// ----------------------------------------------------------------------------
package cpm_pkg;

  localparam int NUM_PORTS = 3;
  localparam int CH_W      = 2;

  localparam int MA_W      = 11;
  localparam int ADC_W     = 10;
  localparam int MAH_W     = 16;
  localparam int LOWC_W    = 16;
  localparam int BLINK_W   = 8;

  // charge is kept as quotient and remainder of the accumulator by 3600
  localparam int          QUO_W     = 21;
  localparam int          REM_W     = 12;
  localparam logic [REM_W-1:0] MAH_DIV = 12'd3600;
  // 2^32 = QUO_MAX * 3600 + WRAP_REM
  localparam logic [QUO_W-1:0] QUO_MAX  = 21'd1193046;
  localparam logic [REM_W-1:0] WRAP_REM = 12'd1696;

  // x / 5 == (x * DIV5_MUL) >> 18 for x < 2^16
  localparam logic [15:0] DIV5_MUL  = 16'd52429;
  // x / 100 == (x * DIV100_MUL) >> 19 for x < 2^11
  localparam logic [12:0] DIV100_MUL = 13'd5243;

  localparam logic [MA_W-1:0]   CUT_THR_RST   = 11'd100;
  localparam logic [LOWC_W-1:0] CUT_TICKS_RST = 16'd180;
  localparam logic [LOWC_W-1:0] LOWC_MAX      = 16'hFFFF;
  localparam logic [BLINK_W-1:0] MISS_LIMIT   = 8'd2;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CUT_THR   = 1'b0;
  localparam logic REG_CUT_TICKS = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_SAMPLE  = 3'd0,
    OP_SECOND  = 3'd1,
    OP_BLINK   = 3'd2,
    OP_REARM   = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_PRELOAD = 3'd5,
    OP_TOGGLE  = 3'd6
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CH_W-1:0]  ch;
    logic             ch_ok;
    logic [MA_W-1:0]  ma;
    logic [MAH_W-1:0] pre;
  } cmd_t;

  typedef struct packed {
    logic [MA_W-1:0]   cut_thr;
    logic [LOWC_W-1:0] cut_ticks;
  } cfg_t;

endpackage

FILE: src/cpm_front.sv
// ----------------------------------------------------------------------------
// cpm_front: event decode
// Checks the channel and scales the converter reading to milliamps.
// ----------------------------------------------------------------------------
module cpm_front (
  input  logic [2:0]                  opcode_i,
  input  logic [cpm_pkg::CH_W-1:0]    channel_i,
  input  logic [cpm_pkg::ADC_W-1:0]   adc_sample_i,
  input  logic [cpm_pkg::MAH_W-1:0]   preload_mah_i,
  output cpm_pkg::cmd_t               cmd_o
);

  logic [12:0] adc_x8;
  logic [28:0] prod;

  // adc * 8 / 5 by reciprocal
  assign adc_x8 = {adc_sample_i, 3'b000};
  assign prod   = 29'(adc_x8) * 29'(cpm_pkg::DIV5_MUL);

  always_comb begin
    cmd_o.op    = cpm_pkg::op_e'(opcode_i);
    cmd_o.ch    = channel_i;
    cmd_o.ch_ok = (32'(channel_i) < cpm_pkg::NUM_PORTS);
    cmd_o.ma    = prod[28:18];
    cmd_o.pre   = preload_mah_i;
  end

endmodule

FILE: src/cpm_queue.sv
// ----------------------------------------------------------------------------
// cpm_queue: decoded event queue
// Short FIFO between decode and execution.
// ----------------------------------------------------------------------------
module cpm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpm_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cpm_pkg::cmd_t pop_data_o
);

  cpm_pkg::cmd_t                  mem_q [cpm_pkg::QDEPTH];
  logic [cpm_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cpm_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == cpm_pkg::QCNT_W'(cpm_pkg::QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == cpm_pkg::QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == cpm_pkg::QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/cpm_back.sv
// ----------------------------------------------------------------------------
// cpm_back: event execution
// Holds the per-port state, applies one event per cycle unless the output stalls, registers the result.
// ----------------------------------------------------------------------------
module cpm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cpm_pkg::cfg_t               cfg_i,
  input  logic                        cmd_valid_i,
  input  cpm_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cpm_pkg::CH_W-1:0]    channel_out_o,
  output logic                        output_on_o,
  output logic                        led_on_o,
  output logic [cpm_pkg::MA_W-1:0]    current_ma_o,
  output logic [cpm_pkg::MAH_W-1:0]   charge_mah_o,
  output logic                        charge_changed_o,
  output logic                        auto_stop_on_o
);

  localparam int NP = cpm_pkg::NUM_PORTS;

  logic [cpm_pkg::MA_W-1:0]    cur_q   [NP];
  logic [cpm_pkg::LOWC_W-1:0]  low_q   [NP];
  logic [cpm_pkg::QUO_W-1:0]   quo_q   [NP];
  logic [cpm_pkg::REM_W-1:0]   rem_q   [NP];
  logic [cpm_pkg::MAH_W-1:0]   last_q  [NP];
  logic [cpm_pkg::BLINK_W-1:0] bcnt_q  [NP];
  logic [cpm_pkg::BLINK_W-1:0] bmiss_q [NP];
  logic [NP-1:0]               outst_q, led_q, auto_q;

  logic [cpm_pkg::MA_W-1:0]    cur_d;
  logic [cpm_pkg::LOWC_W-1:0]  low_d;
  logic [cpm_pkg::QUO_W-1:0]   quo_d;
  logic [cpm_pkg::REM_W-1:0]   rem_d;
  logic [cpm_pkg::MAH_W-1:0]   last_d;
  logic [cpm_pkg::BLINK_W-1:0] bcnt_d, bmiss_d;
  logic                        outst_d, led_d, auto_d, changed_d;

  logic [cpm_pkg::CH_W-1:0]    pidx;
  logic [12:0]                 rsum;
  logic [23:0]                 div100_prod;
  logic [4:0]                  cur_div100;
  logic                        is_low;
  logic [cpm_pkg::LOWC_W-1:0]  low_inc;

  logic                        res_valid_q;
  logic [cpm_pkg::CH_W-1:0]    res_ch_q;
  logic                        res_out_q, res_led_q, res_chg_q, res_auto_q;
  logic [cpm_pkg::MA_W-1:0]    res_cur_q;
  logic [cpm_pkg::MAH_W-1:0]   res_mah_q;

  assign pidx      = cmd_i.ch_ok ? cmd_i.ch : '0;
  assign cmd_pop_o = cmd_valid_i && (!res_valid_q || !out_stall_i);

  assign rsum        = 13'(rem_q[pidx]) + 13'(cur_q[pidx]);
  assign div100_prod = 24'(cur_q[pidx]) * 24'(cpm_pkg::DIV100_MUL);
  assign cur_div100  = div100_prod[23:19];
  assign is_low      = (cmd_i.ma < cfg_i.cut_thr);
  assign low_inc     = (low_q[pidx] == cpm_pkg::LOWC_MAX) ? low_q[pidx] : low_q[pidx] + 1'b1;

  always_comb begin
    cur_d     = cur_q[pidx];
    low_d     = low_q[pidx];
    quo_d     = quo_q[pidx];
    rem_d     = rem_q[pidx];
    last_d    = last_q[pidx];
    bcnt_d    = bcnt_q[pidx];
    bmiss_d   = bmiss_q[pidx];
    outst_d   = outst_q[pidx];
    led_d     = led_q[pidx];
    auto_d    = auto_q[pidx];
    changed_d = 1'b0;
    unique case (cmd_i.op)
      cpm_pkg::OP_SAMPLE: begin
        if (auto_q[pidx]) begin
          cur_d = cmd_i.ma;
          if (is_low) begin
            low_d = low_inc;
            if (low_inc >= cfg_i.cut_ticks) begin
              outst_d = 1'b0;
            end
          end else begin
            low_d = '0;
          end
        end
      end
      cpm_pkg::OP_SECOND: begin
        // 32-bit accumulator wrap lands past QUO_MAX quotients
        if (quo_q[pidx] == cpm_pkg::QUO_MAX && rsum >= 13'(cpm_pkg::WRAP_REM)) begin
          quo_d = '0;
          rem_d = 12'(rsum - 13'(cpm_pkg::WRAP_REM));
        end else if (rsum >= 13'(cpm_pkg::MAH_DIV)) begin
          quo_d = quo_q[pidx] + 1'b1;
          rem_d = 12'(rsum - 13'(cpm_pkg::MAH_DIV));
        end else begin
          rem_d = 12'(rsum);
        end
        if (quo_d[cpm_pkg::MAH_W-1:0] != last_q[pidx]) begin
          last_d    = quo_d[cpm_pkg::MAH_W-1:0];
          changed_d = 1'b1;
        end
      end
      cpm_pkg::OP_BLINK: begin
        bcnt_d = bcnt_q[pidx] + 1'b1;
        if (bcnt_d[0]) begin
          led_d = 1'b0;
        end else if (7'(bcnt_d[7:1]) <= 7'(cur_div100)) begin
          led_d   = 1'b1;
          bmiss_d = '0;
        end else begin
          bmiss_d = bmiss_q[pidx] + 1'b1;
          led_d   = 1'b0;
          if (bmiss_d >= cpm_pkg::MISS_LIMIT) begin
            bcnt_d = '0;
          end
        end
      end
      cpm_pkg::OP_REARM: begin
        outst_d = 1'b1;
        led_d   = 1'b1;
        low_d   = '0;
      end
      cpm_pkg::OP_CLEAR: begin
        quo_d = '0;
        rem_d = '0;
      end
      cpm_pkg::OP_PRELOAD: begin
        quo_d = cpm_pkg::QUO_W'(cmd_i.pre);
        rem_d = '0;
      end
      cpm_pkg::OP_TOGGLE: begin
        if (auto_q[pidx]) begin
          auto_d  = 1'b0;
          outst_d = 1'b1;
        end else begin
          auto_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NP; p++) begin
        cur_q[p]   <= '0;
        low_q[p]   <= '0;
        quo_q[p]   <= '0;
        rem_q[p]   <= '0;
        last_q[p]  <= '0;
        bcnt_q[p]  <= '0;
        bmiss_q[p] <= '0;
      end
      outst_q <= '1;
      led_q   <= '1;
      auto_q  <= '1;
    end else if (cmd_pop_o && cmd_i.ch_ok) begin
      cur_q[pidx]   <= cur_d;
      low_q[pidx]   <= low_d;
      quo_q[pidx]   <= quo_d;
      rem_q[pidx]   <= rem_d;
      last_q[pidx]  <= last_d;
      bcnt_q[pidx]  <= bcnt_d;
      bmiss_q[pidx] <= bmiss_d;
      outst_q[pidx] <= outst_d;
      led_q[pidx]   <= led_d;
      auto_q[pidx]  <= auto_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // out-of-range channel reports its channel number with zeros in all other fields
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_ch_q   <= cmd_i.ch;
      res_out_q  <= cmd_i.ch_ok & outst_d;
      res_led_q  <= cmd_i.ch_ok & led_d;
      res_cur_q  <= cmd_i.ch_ok ? cur_d : '0;
      res_mah_q  <= cmd_i.ch_ok ? quo_d[cpm_pkg::MAH_W-1:0] : '0;
      res_chg_q  <= cmd_i.ch_ok & changed_d;
      res_auto_q <= cmd_i.ch_ok & auto_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign channel_out_o    = res_ch_q;
  assign output_on_o      = res_out_q;
  assign led_on_o         = res_led_q;
  assign current_ma_o     = res_cur_q;
  assign charge_mah_o     = res_mah_q;
  assign charge_changed_o = res_chg_q;
  assign auto_stop_on_o   = res_auto_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> rem_q[pidx] < cpm_pkg::MAH_DIV)
    else $error("charge remainder out of range");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> quo_q[pidx] <= cpm_pkg::QUO_MAX)
    else $error("charge quotient beyond accumulator range");

  a_cut_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o && cmd_i.ch_ok && cmd_i.op == cpm_pkg::OP_SAMPLE && auto_q[pidx] && is_low
      && low_inc >= cfg_i.cut_ticks |=> !outst_q[$past(pidx)])
    else $error("output not switched off after low-current run");

  a_low_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o && cmd_i.ch_ok && cmd_i.op == cpm_pkg::OP_SAMPLE && auto_q[pidx] && is_low
      && low_q[pidx] == cpm_pkg::LOWC_MAX |=> low_q[$past(pidx)] == cpm_pkg::LOWC_MAX)
    else $error("low-current counter wrapped");

endmodule

FILE: src/charge_port_monitor_core.sv
// ----------------------------------------------------------------------------
// charge_port_monitor_core: three-port charging monitor
// A beat accepted at the input sits in the queue, executes when the back end
// pops it and leaves from the result register; output stalls can hold it back.
// Throughput: one item per cycle while out_stall_i is low; the back end
// executes one event per cycle, the two-beat queue absorbs output stalls.
// Reset: all ports output on, LED on, auto-stop on, counters and charge zero;
// cut threshold 100 mA, cut ticks 180.
// ----------------------------------------------------------------------------
module charge_port_monitor_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpm_pkg::ADDR_W-1:0]     paddr,
  input  logic [cpm_pkg::DATA_W-1:0]     pwdata,
  output logic [cpm_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     opcode_i,
  input  logic [cpm_pkg::CH_W-1:0]       channel_i,
  input  logic [cpm_pkg::ADC_W-1:0]      adc_sample_i,
  input  logic [cpm_pkg::MAH_W-1:0]      preload_mah_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cpm_pkg::CH_W-1:0]       channel_out_o,
  output logic                           output_on_o,
  output logic                           led_on_o,
  output logic [cpm_pkg::MA_W-1:0]       current_ma_o,
  output logic [cpm_pkg::MAH_W-1:0]      charge_mah_o,
  output logic                           charge_changed_o,
  output logic                           auto_stop_on_o
);

  cpm_pkg::cfg_t cfg_q;
  cpm_pkg::cmd_t front_cmd, head_cmd;
  logic          q_full, q_valid, q_pop, push;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cut_thr   <= cpm_pkg::CUT_THR_RST;
      cfg_q.cut_ticks <= cpm_pkg::CUT_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == cpm_pkg::REG_CUT_THR) begin
        cfg_q.cut_thr <= pwdata[cpm_pkg::MA_W-1:0];
      end else begin
        cfg_q.cut_ticks <= pwdata[cpm_pkg::LOWC_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == cpm_pkg::REG_CUT_TICKS) begin
      prdata = cpm_pkg::DATA_W'(cfg_q.cut_ticks);
    end else begin
      prdata = cpm_pkg::DATA_W'(cfg_q.cut_thr);
    end
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  cpm_front u_front (
    .opcode_i      (opcode_i),
    .channel_i     (channel_i),
    .adc_sample_i  (adc_sample_i),
    .preload_mah_i (preload_mah_i),
    .cmd_o         (front_cmd)
  );

  cpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_cmd)
  );

  cpm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (q_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_out_o    (channel_out_o),
    .output_on_o      (output_on_o),
    .led_on_o         (led_on_o),
    .current_ma_o     (current_ma_o),
    .charge_mah_o     (charge_mah_o),
    .charge_changed_o (charge_changed_o),
    .auto_stop_on_o   (auto_stop_on_o)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: charge port monitor core
// Drives port events through the valid/stall input channel and compares every
// result beat against an in-bench model of the three ports. The model tracks
// current, low-current run, charge, blink pattern and auto-stop per port.
// Covers the register port, directed corner events, a long low-current
// run and random event mixes under several register settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int CHUNK_EVENTS   = 155;
  localparam int LONG_RUN_TICKS = 200;

  localparam int unsigned SECONDS_PER_HOUR = 3600;
  localparam int unsigned BLINK_STEP_MA    = 100;
  localparam int unsigned BLINK_MISS_MAX   = 2;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [cpm_pkg::CH_W-1:0] CH_NONE = cpm_pkg::CH_W'(cpm_pkg::NUM_PORTS);
  localparam logic [cpm_pkg::ADDR_W-1:0] ADDR_CUT_THR   = {cpm_pkg::REG_CUT_THR, 2'b00};
  localparam logic [cpm_pkg::ADDR_W-1:0] ADDR_CUT_TICKS = {cpm_pkg::REG_CUT_TICKS, 2'b00};

  typedef struct packed {
    logic [cpm_pkg::CH_W-1:0]  ch;
    logic                      out_on;
    logic                      led;
    logic [cpm_pkg::MA_W-1:0]  ma;
    logic [cpm_pkg::MAH_W-1:0] mah;
    logic                      changed;
    logic                      auto_stop;
  } port_status_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [cpm_pkg::ADDR_W-1:0]     paddr = '0;
  logic [cpm_pkg::DATA_W-1:0]     pwdata = '0;
  logic [cpm_pkg::DATA_W-1:0]     prdata;
  logic                           pready;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [2:0]                     opcode_i = '0;
  logic [cpm_pkg::CH_W-1:0]       channel_i = '0;
  logic [cpm_pkg::ADC_W-1:0]      adc_sample_i = '0;
  logic [cpm_pkg::MAH_W-1:0]      preload_mah_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [cpm_pkg::CH_W-1:0]       channel_out_o;
  logic                           output_on_o;
  logic                           led_on_o;
  logic [cpm_pkg::MA_W-1:0]       current_ma_o;
  logic [cpm_pkg::MAH_W-1:0]      charge_mah_o;
  logic                           charge_changed_o;
  logic                           auto_stop_on_o;

  charge_port_monitor_core dut (.*);

  // per-port model state
  logic [cpm_pkg::MA_W-1:0]    port_ma      [cpm_pkg::NUM_PORTS];
  logic [cpm_pkg::LOWC_W-1:0]  low_run      [cpm_pkg::NUM_PORTS];
  logic [31:0]                 charge_acc_q [cpm_pkg::NUM_PORTS];
  logic [cpm_pkg::MAH_W-1:0]   mah_seen     [cpm_pkg::NUM_PORTS];
  logic [cpm_pkg::BLINK_W-1:0] blink_phase  [cpm_pkg::NUM_PORTS];
  logic [cpm_pkg::BLINK_W-1:0] blink_misses [cpm_pkg::NUM_PORTS];
  logic                        out_en       [cpm_pkg::NUM_PORTS];
  logic                        led_lit      [cpm_pkg::NUM_PORTS];
  logic                        auto_cut     [cpm_pkg::NUM_PORTS];
  logic [cpm_pkg::MA_W-1:0]    thr_ma;
  logic [cpm_pkg::LOWC_W-1:0]  cut_after;

  port_status_t pending_status[$];
  bit           idle_en = 1'b0;
  int           errors = 0;
  int           events_sent = 0;
  int           results_seen = 0;
  int           cycles = 0;
  int           stall_left = 0;
  int           settings_used = 0;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic port_status_t apply_event(input logic [2:0] op,
                                               input logic [cpm_pkg::CH_W-1:0] ch,
                                               input logic [cpm_pkg::ADC_W-1:0] adc,
                                               input logic [cpm_pkg::MAH_W-1:0] pre);
    port_status_t res;
    logic [cpm_pkg::MAH_W-1:0] mah;
    int p;
    res = '0;
    res.ch = ch;
    if (ch >= cpm_pkg::NUM_PORTS) return res;
    p = int'(ch);
    case (op)
      cpm_pkg::OP_SAMPLE: if (auto_cut[p]) begin
        port_ma[p] = cpm_pkg::MA_W'((32'(adc) * 8) / 5);
        if (port_ma[p] < thr_ma) begin
          if (low_run[p] != cpm_pkg::LOWC_MAX) low_run[p]++;
          if (low_run[p] >= cut_after) out_en[p] = 1'b0;
        end else begin
          low_run[p] = '0;
        end
      end
      cpm_pkg::OP_SECOND: begin
        charge_acc_q[p] = charge_acc_q[p] + 32'(port_ma[p]);
        mah = cpm_pkg::MAH_W'(charge_acc_q[p] / SECONDS_PER_HOUR);
        if (mah != mah_seen[p]) begin
          mah_seen[p] = mah;
          res.changed = 1'b1;
        end
      end
      cpm_pkg::OP_BLINK: begin
        blink_phase[p]++;
        if (blink_phase[p][0]) begin
          led_lit[p] = 1'b0;
        end else if (32'(blink_phase[p] >> 1) <= 32'(port_ma[p]) / BLINK_STEP_MA) begin
          led_lit[p] = 1'b1;
          blink_misses[p] = '0;
        end else begin
          blink_misses[p]++;
          led_lit[p] = 1'b0;
          if (blink_misses[p] >= BLINK_MISS_MAX) blink_phase[p] = '0;
        end
      end
      cpm_pkg::OP_REARM: begin
        out_en[p] = 1'b1;
        led_lit[p] = 1'b1;
        low_run[p] = '0;
      end
      cpm_pkg::OP_CLEAR:   charge_acc_q[p] = '0;
      cpm_pkg::OP_PRELOAD: charge_acc_q[p] = 32'(pre) * SECONDS_PER_HOUR;
      cpm_pkg::OP_TOGGLE: begin
        if (auto_cut[p]) begin
          auto_cut[p] = 1'b0;
          out_en[p] = 1'b1;
        end else begin
          auto_cut[p] = 1'b1;
        end
      end
      default: ;
    endcase
    res.out_on = out_en[p];
    res.led = led_lit[p];
    res.ma = port_ma[p];
    res.mah = cpm_pkg::MAH_W'(charge_acc_q[p] / SECONDS_PER_HOUR);
    res.auto_stop = auto_cut[p];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    port_status_t want;
    if (pending_status.size() == 0) begin
      $error("result beat on channel %0d with no event pending", channel_out_o);
      errors++;
    end else begin
      want = pending_status.pop_front();
      check_field("channel_out", 32'(want.ch), 32'(channel_out_o));
      check_field("output_on", 32'(want.out_on), 32'(output_on_o));
      check_field("led_on", 32'(want.led), 32'(led_on_o));
      check_field("current_ma", 32'(want.ma), 32'(current_ma_o));
      check_field("charge_mah", 32'(want.mah), 32'(charge_mah_o));
      check_field("charge_changed", 32'(want.changed), 32'(charge_changed_o));
      check_field("auto_stop_on", 32'(want.auto_stop), 32'(auto_stop_on_o));
      results_seen++;
    end
  endtask

  // result side: checking, output stall bursts, watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) check_result();
      if (stall_left != 0) stall_left--;
      else if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      out_stall_i <= (stall_left != 0);
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [cpm_pkg::CH_W-1:0] ch,
                            input logic [cpm_pkg::ADC_W-1:0] adc,
                            input logic [cpm_pkg::MAH_W-1:0] pre);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    channel_i <= ch;
    adc_sample_i <= adc;
    preload_mah_i <= pre;
    do @(posedge clk_i); while (in_stall_o);
    pending_status.push_back(apply_event(op, ch, adc, pre));
    events_sent++;
  endtask

  // hold the sender until every pending result is back, then let the core settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // leaves psel up so a following transfer goes straight to its setup cycle
  task automatic apb_access(input logic wr, input logic [cpm_pkg::ADDR_W-1:0] addr,
                            input logic [cpm_pkg::DATA_W-1:0] data,
                            output logic [cpm_pkg::DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
  endtask

  task automatic set_limits(input logic [cpm_pkg::MA_W-1:0] thr,
                            input logic [cpm_pkg::LOWC_W-1:0] ticks);
    logic [cpm_pkg::DATA_W-1:0] rd;
    wait_drained();
    apb_access(1'b1, ADDR_CUT_THR, cpm_pkg::DATA_W'(thr), rd);
    apb_access(1'b1, ADDR_CUT_TICKS, cpm_pkg::DATA_W'(ticks), rd);
    thr_ma = thr;
    cut_after = ticks;
    apb_access(1'b0, ADDR_CUT_THR, '0, rd);
    check_field("cut_threshold_ma readback", 32'(thr), 32'(rd[cpm_pkg::MA_W-1:0]));
    apb_access(1'b0, ADDR_CUT_TICKS, '0, rd);
    check_field("cut_ticks readback", 32'(ticks), 32'(rd[cpm_pkg::LOWC_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_event();
    logic [2:0] op;
    logic [cpm_pkg::CH_W-1:0] ch;
    logic [cpm_pkg::ADC_W-1:0] adc;
    logic [cpm_pkg::MAH_W-1:0] pre;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = cpm_pkg::OP_SAMPLE;
    else if (pick < 55) op = cpm_pkg::OP_SECOND;
    else if (pick < 75) op = cpm_pkg::OP_BLINK;
    else if (pick < 81) op = cpm_pkg::OP_REARM;
    else if (pick < 86) op = cpm_pkg::OP_CLEAR;
    else if (pick < 91) op = cpm_pkg::OP_PRELOAD;
    else if (pick < 97) op = cpm_pkg::OP_TOGGLE;
    else                op = OP_UNUSED;
    ch = ($urandom_range(0, 19) == 0) ? CH_NONE :
         cpm_pkg::CH_W'($urandom_range(0, cpm_pkg::NUM_PORTS - 1));
    // half the samples sit near the cut threshold so low-current runs build up
    adc = $urandom_range(0, 1) ? cpm_pkg::ADC_W'($urandom_range(0, 80)) :
          cpm_pkg::ADC_W'($urandom);
    pre = ($urandom_range(0, 3) == 0) ? cpm_pkg::MAH_W'($urandom) :
          cpm_pkg::MAH_W'($urandom_range(0, 50));
    send_event(op, ch, adc, pre);
  endtask

  task automatic test_directed_events();
    send_event(cpm_pkg::OP_BLINK, 2'd0, '0, '0);
    send_event(cpm_pkg::OP_SAMPLE, 2'd0, '0, '0);
    send_event(cpm_pkg::OP_SAMPLE, 2'd1, '1, '0);
    send_event(cpm_pkg::OP_SECOND, 2'd1, '0, '0);
    repeat (3) send_event(cpm_pkg::OP_BLINK, 2'd1, '0, '0);
    // charge beyond 65535 mAh reports the low 16 bits
    send_event(cpm_pkg::OP_PRELOAD, 2'd2, '0, '1);
    send_event(cpm_pkg::OP_SAMPLE, 2'd2, '1, '0);
    repeat (3) send_event(cpm_pkg::OP_SECOND, 2'd2, '0, '0);
    send_event(cpm_pkg::OP_CLEAR, 2'd2, '0, '0);
    send_event(cpm_pkg::OP_SECOND, 2'd2, '0, '0);
    // auto-stop off: samples are ignored
    send_event(cpm_pkg::OP_TOGGLE, 2'd0, '0, '0);
    send_event(cpm_pkg::OP_SAMPLE, 2'd0, '1, '0);
    send_event(cpm_pkg::OP_TOGGLE, 2'd0, '0, '0);
    send_event(cpm_pkg::OP_REARM, 2'd1, '0, '0);
    send_event(OP_UNUSED, 2'd1, '1, '1);
    send_event(cpm_pkg::OP_SAMPLE, CH_NONE, '1, '1);
    send_event(OP_UNUSED, CH_NONE, '0, '0);
  endtask

  task automatic test_cut_off();
    set_limits('1, 16'd1);
    send_event(cpm_pkg::OP_SAMPLE, 2'd0, 10'd5, '0);
    send_event(cpm_pkg::OP_TOGGLE, 2'd0, '0, '0);
    send_event(cpm_pkg::OP_TOGGLE, 2'd0, '0, '0);
    send_event(cpm_pkg::OP_SAMPLE, 2'd1, 10'd3, '0);
    send_event(cpm_pkg::OP_REARM, 2'd1, '0, '0);
  endtask

  // long low-current run: the cut lands exactly on the programmed tick count
  task automatic test_long_low_run();
    idle_en = 1'b0;
    set_limits('1, cpm_pkg::LOWC_W'(LONG_RUN_TICKS));
    send_event(cpm_pkg::OP_REARM, 2'd1, '0, '0);
    repeat (LONG_RUN_TICKS + 3) send_event(cpm_pkg::OP_SAMPLE, 2'd1, 10'd1, '0);
    send_event(cpm_pkg::OP_REARM, 2'd1, '0, '0);
    idle_en = 1'b1;
  endtask

  task automatic test_random_mix(input logic [cpm_pkg::MA_W-1:0] thr,
                                 input logic [cpm_pkg::LOWC_W-1:0] ticks,
                                 input bit with_idle);
    set_limits(thr, ticks);
    idle_en = with_idle;
    repeat (CHUNK_EVENTS) send_random_event();
  endtask

  initial begin
    for (int p = 0; p < cpm_pkg::NUM_PORTS; p++) begin
      port_ma[p] = '0;
      low_run[p] = '0;
      charge_acc_q[p] = '0;
      mah_seen[p] = '0;
      blink_phase[p] = '0;
      blink_misses[p] = '0;
      out_en[p] = 1'b1;
      led_lit[p] = 1'b1;
      auto_cut[p] = 1'b1;
    end
    thr_ma = cpm_pkg::CUT_THR_RST;
    cut_after = cpm_pkg::CUT_TICKS_RST;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en = 1'b1;

    test_directed_events();
    test_cut_off();
    test_long_low_run();
    test_random_mix(cpm_pkg::CUT_THR_RST, cpm_pkg::CUT_TICKS_RST, 1'b1);
    test_random_mix('1, 16'd1, 1'b1);
    test_random_mix('0, cpm_pkg::LOWC_MAX, 1'b1);
    test_random_mix(11'd400, 16'd3, 1'b1);
    test_random_mix(cpm_pkg::MA_W'($urandom_range(0, 2047)),
                    cpm_pkg::LOWC_W'($urandom_range(1, 20)), 1'b1);
    test_random_mix(11'd150, 16'd2, 1'b0);

    wait_drained();
    $display("testbench: %0d events sent, %0d result beats checked, %0d register settings",
             events_sent, results_seen, settings_used);
    $display("testbench: covered all event codes, unused code, bad channel, cut-off and mAh wrap");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
